>>> sv/audio_test_signal_generator_unit_assert.svh
// Assertion macros used by the test signal generator controller RTL.
`ifndef AUDIO_TEST_SIGNAL_GENERATOR_UNIT_ASSERT_SVH
`define AUDIO_TEST_SIGNAL_GENERATOR_UNIT_ASSERT_SVH

// Check a consequence in the same cycle as its condition.
`define ATSG_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequence in the cycle after its condition.
`define ATSG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/atsg_pkg.sv
// Shared constants, codes and command type of the test signal generator.
`default_nettype none

package atsg_pkg;

   localparam int SINE_TABLE_DEPTH = 1024;
   localparam int SINE_AW          = $clog2(SINE_TABLE_DEPTH);

   localparam int PHASE_W    = 32;
   localparam int SAMPLE_W   = 16;
   localparam int GAIN_W     = 16;
   localparam int MODE_W     = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam int NUM_TAPS   = 7;
   localparam int NUM_POLES  = NUM_TAPS - 1;
   localparam int TAP_IDX_W  = $clog2(NUM_TAPS);
   localparam int TAP_W      = 32;
   localparam int COEF_W     = 25;

   // Modes
   localparam logic [MODE_W-1:0] MODE_SINE  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_WHITE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PINK  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_OFF   = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODE       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PHASE_STEP = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN       = 2'd2;

   localparam logic [MODE_W-1:0]  MODE_RESET       = MODE_OFF;
   localparam logic [PHASE_W-1:0] PHASE_STEP_RESET = '0;
   localparam logic [GAIN_W-1:0]  GAIN_RESET       = 16'd32768;

   // Pink filter coefficients, Q0.24
   localparam logic signed [COEF_W-1:0] POLE_Q24 [NUM_POLES] = '{
      COEF_W'(16758090), COEF_W'(16665144), COEF_W'(16257122),
      COEF_W'(14537458), COEF_W'(9227469),  COEF_W'(-12777528)
   };
   localparam logic signed [COEF_W-1:0] FEED_Q24 [NUM_POLES] = '{
      COEF_W'(931436),  COEF_W'(1259565), COEF_W'(2581208),
      COEF_W'(5209084), COEF_W'(8941454), COEF_W'(-283501)
   };
   localparam logic signed [COEF_W-1:0] K_OUT_SCALE    = COEF_W'(1342177);
   localparam logic signed [COEF_W-1:0] K_WHITE_DIRECT = COEF_W'(8995943);
   localparam logic signed [COEF_W-1:0] K_LAST_TAP     = COEF_W'(1944916);

   // Controller to datapath commands
   typedef struct packed {
      logic                 load;
      logic                 rom_rd;
      logic                 tap_mul;
      logic [TAP_IDX_W-1:0] mul_idx;
      logic                 tap_fin;
      logic [TAP_IDX_W-1:0] fin_idx;
      logic                 sum_init;
      logic                 sum_fix;
      logic                 scale_mul;
      logic                 scale_rnd;
      logic                 gain_mul;
      logic                 out_load;
   } atsg_cmd_type;

endpackage

`default_nettype wire

>>> sv/atsg_intf.sv
// Handshake channel interfaces of the test signal generator.
`default_nettype none

interface atsg_req_if import atsg_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] noise_sample;
   logic                       buffer_start;

   modport source (output valid, output noise_sample, output buffer_start, input ready);
   modport sink   (input valid, input noise_sample, input buffer_start, output ready);
endinterface

interface atsg_rsp_if import atsg_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_out;

   modport source (output valid, output sample_out, input ready);
   modport sink   (input valid, input sample_out, output ready);
endinterface

interface atsg_csr_if import atsg_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  reg_index;
   logic [CSR_DATA_W-1:0] wdata;

   modport source (output valid, output reg_index, output wdata, input ready);
   modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

>>> sv/atsg_csr.sv
// Configuration registers: mode, phase step and gain.
`default_nettype none

module atsg_csr import atsg_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic [MODE_W-1:0]     mode,
   output logic [PHASE_W-1:0]    phase_step,
   output logic [GAIN_W-1:0]     gain
);

   logic [MODE_W-1:0]  mode_ff, mode_in;
   logic [PHASE_W-1:0] step_ff, step_in;
   logic [GAIN_W-1:0]  gain_ff, gain_in;

   assign csr_ready = 1'b1;

   always_comb begin
      mode_in = mode_ff;
      step_in = step_ff;
      gain_in = gain_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_MODE:       mode_in = csr_wdata[MODE_W-1:0];
            CSR_PHASE_STEP: step_in = csr_wdata[PHASE_W-1:0];
            CSR_GAIN:       gain_in = csr_wdata[GAIN_W-1:0];
            default: ;  // drop writes to unmapped indexes
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_RESET;
         step_ff <= PHASE_STEP_RESET;
         gain_ff <= GAIN_RESET;
      end else begin
         mode_ff <= mode_in;
         step_ff <= step_in;
         gain_ff <= gain_in;
      end
   end

   assign mode       = mode_ff;
   assign phase_step = step_ff;
   assign gain       = gain_ff;

endmodule

`default_nettype wire

>>> sv/atsg_ctrl.sv
// Sequencing state machine: accepts a word, steps the datapath, hands off the result.
`default_nettype none
`include "audio_test_signal_generator_unit_assert.svh"

module atsg_ctrl import atsg_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [MODE_W-1:0] mode,
   output atsg_cmd_type      cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_ROM    = 3'd1;
   localparam logic [2:0] ST_TAP    = 3'd2;
   localparam logic [2:0] ST_PSUM   = 3'd3;
   localparam logic [2:0] ST_SCALE  = 3'd4;
   localparam logic [2:0] ST_SROUND = 3'd5;
   localparam logic [2:0] ST_GAIN   = 3'd6;
   localparam logic [2:0] ST_DONE   = 3'd7;

   localparam logic [TAP_IDX_W-1:0] LAST_CNT = TAP_IDX_W'(NUM_POLES);

   logic [2:0]           state_ff, state_in;
   logic [TAP_IDX_W-1:0] cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               case (mode)
                  MODE_SINE:  state_in = ST_ROM;
                  MODE_WHITE: state_in = ST_GAIN;
                  MODE_PINK:  state_in = ST_TAP;
                  default:    state_in = ST_DONE;
               endcase
            end
         end
         ST_ROM: begin
            cmd.rom_rd = 1'b1;
            state_in   = ST_GAIN;
         end
         ST_TAP: begin
            // multiply section cnt while finishing section cnt-1
            if (cnt_ff != LAST_CNT) begin
               cmd.tap_mul = 1'b1;
               cmd.mul_idx = cnt_ff;
            end
            if (cnt_ff == '0) begin
               cmd.sum_init = 1'b1;
            end else begin
               cmd.tap_fin = 1'b1;
               cmd.fin_idx = cnt_ff - TAP_IDX_W'(1);
            end
            if (cnt_ff == LAST_CNT) begin
               state_in = ST_PSUM;
            end else begin
               cnt_in = cnt_ff + TAP_IDX_W'(1);
            end
         end
         ST_PSUM: begin
            cmd.sum_fix = 1'b1;
            state_in    = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale_mul = 1'b1;
            state_in      = ST_SROUND;
         end
         ST_SROUND: begin
            cmd.scale_rnd = 1'b1;
            state_in      = ST_GAIN;
         end
         ST_GAIN: begin
            cmd.gain_mul = 1'b1;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `ATSG_ASSERT_NEXT(a_accept_starts, clock, reset, accept, state_ff != ST_IDLE, "accepted word left controller idle")
   `ATSG_ASSERT_SAME(a_load_when_free, clock, reset, cmd.out_load, !rsp_valid_ff || rsp_ready, "result loaded over an unread word")
   `ATSG_ASSERT_NEXT(a_done_holds, clock, reset, state_ff == ST_DONE && rsp_valid_ff && !rsp_ready, state_ff == ST_DONE && rsp_valid_ff, "stalled result not held")
   `ATSG_ASSERT_SAME(a_tap_cnt_range, clock, reset, state_ff == ST_TAP, cnt_ff <= LAST_CNT, "section counter out of range")

endmodule

`default_nettype wire

>>> sv/atsg_dp.sv
// Datapath: phase accumulator, sine table, pink filter sections, gain and saturation.
`default_nettype none

module atsg_dp import atsg_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  atsg_cmd_type               cmd,
   input  logic signed [SAMPLE_W-1:0] noise_sample,
   input  logic                       buffer_start,
   input  logic [MODE_W-1:0]          mode,
   input  logic [PHASE_W-1:0]         phase_step,
   input  logic [GAIN_W-1:0]          gain,
   output logic signed [SAMPLE_W-1:0] sample_out
);

   localparam int PP_W   = COEF_W + TAP_W;
   localparam int PF_W   = COEF_W + SAMPLE_W;
   localparam int ACC_W  = PP_W + 1;
   localparam int XK_W   = COEF_W + SAMPLE_W;
   localparam int SUM_W  = TAP_W + 3;
   localparam int PROD_W = SUM_W + 22;
   localparam int RND_W  = PROD_W + 1;
   localparam int S2_W   = PROD_W - 24;

   localparam logic signed [ACC_W-1:0] TAP_MAX = ACC_W'(2147483647);
   localparam logic signed [ACC_W-1:0] TAP_MIN = -TAP_MAX - ACC_W'(1);
   localparam logic signed [RND_W-1:0] SMP_MAX = RND_W'(32767);
   localparam logic signed [RND_W-1:0] SMP_MIN = -SMP_MAX - RND_W'(1);

   typedef logic signed [SAMPLE_W-1:0] sine_rom_type [SINE_TABLE_DEPTH];

   // sin(pi/2 * t), t in Q.30 over 0..1, result Q1.15
   function automatic logic [SAMPLE_W-1:0] quarter_sine(input logic [63:0] t);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] h;
      logic [63:0] s;
      logic [63:0] r;
      x  = (t * 64'd1686629713) >> 30;
      x2 = (x * x) >> 30;
      h  = 64'd1073741824;
      h  = 64'd1073741824 - ((x2 * h) >> 30) / 64'd110;
      h  = 64'd1073741824 - ((x2 * h) >> 30) / 64'd72;
      h  = 64'd1073741824 - ((x2 * h) >> 30) / 64'd42;
      h  = 64'd1073741824 - ((x2 * h) >> 30) / 64'd20;
      h  = 64'd1073741824 - ((x2 * h) >> 30) / 64'd6;
      s  = (x * h) >> 30;
      r  = (s + 64'd16384) >> 15;
      if (r > 64'd32767) r = 64'd32767;
      return r[SAMPLE_W-1:0];
   endfunction

   function automatic sine_rom_type build_sine();
      sine_rom_type rom;
      logic [63:0]  a;
      logic [63:0]  r;
      logic [SAMPLE_W-1:0] v;
      for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
         a = 64'(i) << (32 - SINE_AW);
         r = a & 64'h3FFF_FFFF;
         v = a[30] ? quarter_sine(64'd1073741824 - r) : quarter_sine(r);
         rom[i] = a[31] ? -$signed(v) : $signed(v);
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine();

   function automatic logic signed [TAP_W-1:0] sat_tap(input logic signed [ACC_W-1:0] v);
      if (v > TAP_MAX) return TAP_W'(TAP_MAX);
      if (v < TAP_MIN) return TAP_W'(TAP_MIN);
      return TAP_W'(v);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] sat_smp(input logic signed [RND_W-1:0] v);
      if (v > SMP_MAX) return SAMPLE_W'(SMP_MAX);
      if (v < SMP_MIN) return SAMPLE_W'(SMP_MIN);
      return SAMPLE_W'(v);
   endfunction

   logic [PHASE_W-1:0]         phase_ff, phase_in;
   logic signed [TAP_W-1:0]    taps_ff [NUM_TAPS];
   logic signed [TAP_W-1:0]    taps_in [NUM_TAPS];
   logic signed [SAMPLE_W-1:0] x_ff, x_in;
   logic signed [SAMPLE_W-1:0] rom_ff, rom_in;
   logic signed [PP_W-1:0]     pp_ff, pp_in;
   logic signed [PF_W-1:0]     pf_ff, pf_in;
   logic signed [XK_W-1:0]     pw_ff, pw_in;
   logic signed [XK_W-1:0]     pl_ff, pl_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [S2_W-1:0]     s2_ff, s2_in;
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;

   logic signed [TAP_W-1:0]    tap_rd;
   logic signed [COEF_W-1:0]   pole_rd;
   logic signed [COEF_W-1:0]   feed_rd;
   logic signed [ACC_W-1:0]    sec_acc;
   logic signed [ACC_W-1:0]    sec_rnd;
   logic signed [TAP_W-1:0]    fin_val;
   logic signed [ACC_W-1:0]    white_rnd;
   logic signed [ACC_W-1:0]    last_rnd;
   logic signed [S2_W-1:0]     gain_op;
   logic signed [GAIN_W:0]     gain_s;
   logic signed [RND_W-1:0]    prod_ext;
   logic signed [RND_W-1:0]    r12;
   logic signed [RND_W-1:0]    r15;
   logic signed [RND_W-1:0]    r24;
   logic signed [RND_W-1:0]    y_val;

   always_comb begin
      tap_rd  = '0;
      pole_rd = '0;
      feed_rd = '0;
      for (int k = 0; k < NUM_POLES; k++) begin
         if (cmd.mul_idx == TAP_IDX_W'(k)) begin
            tap_rd  = taps_ff[k];
            pole_rd = POLE_Q24[k];
            feed_rd = FEED_Q24[k];
         end
      end
   end

   // section update: round(pole*tap + feed*x*2^12, 24), saturated
   assign sec_acc   = ACC_W'(pp_ff) + (ACC_W'(pf_ff) <<< 12);
   assign sec_rnd   = (sec_acc + ACC_W'(1 << 23)) >>> 24;
   assign fin_val   = sat_tap(sec_rnd);
   assign white_rnd = (ACC_W'(pw_ff) + ACC_W'(1 << 11)) >>> 12;
   assign last_rnd  = (ACC_W'(pl_ff) + ACC_W'(1 << 11)) >>> 12;

   assign prod_ext = RND_W'(prod_ff);
   assign r12      = (prod_ext + RND_W'(1 << 11)) >>> 12;
   assign r15      = (prod_ext + RND_W'(1 << 14)) >>> 15;
   assign r24      = (prod_ext + RND_W'(1 << 23)) >>> 24;
   assign gain_s   = $signed({1'b0, gain});

   always_comb begin
      case (mode)
         MODE_SINE:  gain_op = S2_W'(rom_ff);
         MODE_WHITE: gain_op = S2_W'(x_ff);
         default:    gain_op = s2_ff;
      endcase
      case (mode)
         MODE_SINE:  y_val = r15;
         MODE_WHITE: y_val = r12;
         MODE_PINK:  y_val = r24;
         default:    y_val = '0;
      endcase
   end

   always_comb begin
      x_in      = cmd.load ? noise_sample : x_ff;
      phase_in  = cmd.rom_rd ? phase_ff + phase_step : phase_ff;
      rom_in    = cmd.rom_rd ? SINE_ROM[phase_ff[PHASE_W-1 -: SINE_AW]] : rom_ff;
      pp_in     = cmd.tap_mul ? PP_W'(pole_rd) * PP_W'(tap_rd) : pp_ff;
      pf_in     = cmd.tap_mul ? PF_W'(feed_rd) * PF_W'(x_ff) : pf_ff;
      pw_in     = cmd.sum_init ? XK_W'(K_WHITE_DIRECT) * XK_W'(x_ff) : pw_ff;
      pl_in     = cmd.sum_init ? XK_W'(K_LAST_TAP) * XK_W'(x_ff) : pl_ff;
      s2_in     = cmd.scale_rnd ? S2_W'(r24) : s2_ff;
      sample_in = cmd.out_load ? sat_smp(y_val) : sample_ff;

      sum_in = sum_ff;
      if (cmd.sum_init) begin
         sum_in = SUM_W'(taps_ff[NUM_TAPS-1]);
      end else if (cmd.tap_fin) begin
         sum_in = sum_ff + SUM_W'(fin_val);
      end else if (cmd.sum_fix) begin
         sum_in = sum_ff + SUM_W'(white_rnd);
      end

      prod_in = prod_ff;
      if (cmd.scale_mul) begin
         prod_in = PROD_W'(sum_ff) * PROD_W'(K_OUT_SCALE);
      end else if (cmd.gain_mul) begin
         prod_in = PROD_W'(gain_op) * PROD_W'(gain_s);
      end

      for (int k = 0; k < NUM_TAPS; k++) begin
         taps_in[k] = taps_ff[k];
         // clear filter state on the first word of a buffer
         if (cmd.load && buffer_start) begin
            taps_in[k] = '0;
         end
         if (cmd.tap_fin && cmd.fin_idx == TAP_IDX_W'(k)) begin
            taps_in[k] = fin_val;
         end
      end
      if (cmd.sum_fix) begin
         taps_in[NUM_TAPS-1] = sat_tap(last_rnd);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         taps_ff  <= '{default: '0};
      end else begin
         phase_ff <= phase_in;
         taps_ff  <= taps_in;
      end
      x_ff      <= x_in;
      rom_ff    <= rom_in;
      pp_ff     <= pp_in;
      pf_ff     <= pf_in;
      pw_ff     <= pw_in;
      pl_ff     <= pl_in;
      sum_ff    <= sum_in;
      prod_ff   <= prod_in;
      s2_ff     <= s2_in;
      sample_ff <= sample_in;
   end

   assign sample_out = sample_ff;

endmodule

`default_nettype wire

>>> sv/audio_test_signal_generator_unit.sv
// Top level of the audio test signal generator.
//
//   channel   | dir | payload                       | handshake
//   req_chan  | in  | noise_sample, buffer_start    | valid/ready
//   rsp_chan  | out | sample_out                    | valid/ready
//   csr_chan  | in  | reg_index, wdata              | valid/ready, always ready
//
// Steps per word: off goes straight to the output; white applies gain; sine adds
// a registered sine table read before gain; pink runs six filter sections through
// two multipliers, one section a cycle, then scale and gain.
// One word is in work at a time; the output register holds the last result, so
// a new word is taken while it waits. A stalled output holds only the final step.
// Reset is synchronous: mode off, gain 32768 (1.0 in sine mode), phase and filter state cleared.
`default_nettype none

module audio_test_signal_generator_unit import atsg_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   atsg_req_if.sink  req_chan,
   atsg_rsp_if.source rsp_chan,
   atsg_csr_if.sink  csr_chan
);

   logic [MODE_W-1:0]  mode;
   logic [PHASE_W-1:0] phase_step;
   logic [GAIN_W-1:0]  gain;
   atsg_cmd_type       cmd;

   atsg_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_chan.valid),
      .csr_ready  (csr_chan.ready),
      .csr_index  (csr_chan.reg_index),
      .csr_wdata  (csr_chan.wdata),
      .mode       (mode),
      .phase_step (phase_step),
      .gain       (gain)
   );

   atsg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .mode      (mode),
      .cmd       (cmd)
   );

   atsg_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .noise_sample (req_chan.noise_sample),
      .buffer_start (req_chan.buffer_start),
      .mode         (mode),
      .phase_step   (phase_step),
      .gain         (gain),
      .sample_out   (rsp_chan.sample_out)
   );

endmodule

`default_nettype wire

>>> dv/tb_audio_test_signal_generator_unit.sv
`timescale 1ns / 100ps
// Testbench for the audio test signal generator: predicts every sample and checks the output.
module tb_audio_test_signal_generator_unit import atsg_pkg::*; ();

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam longint unsigned Q30_ONE     = 64'd1073741824;
   localparam longint unsigned Q30_HALF_PI = 64'd1686629713;
   localparam longint PINK_OUT_GAIN = 1342177;   // 0.08
   localparam longint PINK_DIRECT   = 8995943;   // 0.5362
   localparam longint PINK_TAIL     = 1944916;   // 0.115926
   localparam longint TAP_MAX       = (longint'(1) <<< 31) - 1;
   localparam longint TAP_MIN       = -(longint'(1) <<< 31);
   localparam int     MAX_IDLE      = 18;

   logic clock;
   logic reset;

   atsg_req_if req_if ();
   atsg_rsp_if rsp_if ();
   atsg_csr_if csr_if ();

   audio_test_signal_generator_unit u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // Predictor state
   logic [MODE_W-1:0]  cur_mode;
   logic [PHASE_W-1:0] cur_step;
   logic [GAIN_W-1:0]  cur_gain;
   logic [PHASE_W-1:0] phase;
   int                 pink_tap [NUM_TAPS];

   logic signed [SAMPLE_W-1:0] pending_samples [$];
   int mismatches = 0;
   bit idling     = 1'b1;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic longint section_pole(int k);
      case (k)
         0: return 16758090;
         1: return 16665144;
         2: return 16257122;
         3: return 14537458;
         4: return 9227469;
         default: return -12777528;
      endcase
   endfunction

   function automatic longint section_feed(int k);
      case (k)
         0: return 931436;
         1: return 1259565;
         2: return 2581208;
         3: return 5209084;
         4: return 8941454;
         default: return -283501;
      endcase
   endfunction

   // Shift right, rounding half up
   function automatic longint round_off(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic longint clamp(longint v, longint lo, longint hi);
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   // sin(pi/2 * t), t in Q.30 over 0..1, Taylor series to x^11 in nested form
   function automatic longint quarter_wave(longint unsigned t);
      longint unsigned x, x2, h, r;
      x  = (t * Q30_HALF_PI) >> 30;
      x2 = (x * x) >> 30;
      h  = Q30_ONE;
      h  = Q30_ONE - ((x2 * h) >> 30) / 110;
      h  = Q30_ONE - ((x2 * h) >> 30) / 72;
      h  = Q30_ONE - ((x2 * h) >> 30) / 42;
      h  = Q30_ONE - ((x2 * h) >> 30) / 20;
      h  = Q30_ONE - ((x2 * h) >> 30) / 6;
      r  = (((x * h) >> 30) + (64'd1 << 14)) >> 15;
      if (r > 32767) r = 32767;
      return longint'(r);
   endfunction

   function automatic longint sine_value(logic [PHASE_W-1:0] acc);
      longint unsigned slot, angle, frac;
      longint mag;
      slot  = ({32'd0, acc} * SINE_TABLE_DEPTH) >> 32;
      angle = (slot << 32) / SINE_TABLE_DEPTH;
      frac  = angle & (Q30_ONE - 1);
      mag   = angle[30] ? quarter_wave(Q30_ONE - frac) : quarter_wave(frac);
      return angle[31] ? -mag : mag;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] predict_sample(
         logic signed [SAMPLE_W-1:0] noise, logic first);
      longint x, g, y, sum;
      x = noise;
      g = cur_gain;
      y = 0;
      if (first)
         for (int k = 0; k < NUM_TAPS; k++) pink_tap[k] = 0;
      case (cur_mode)
         MODE_SINE: begin
            y = round_off(sine_value(phase) * g, 15);
            phase = phase + cur_step;
         end
         MODE_WHITE: y = round_off(x * g, 12);
         MODE_PINK: begin
            for (int k = 0; k < NUM_TAPS - 1; k++)
               pink_tap[k] = int'(clamp(round_off(section_pole(k) * pink_tap[k]
                                  + section_feed(k) * x * 4096, 24), TAP_MIN, TAP_MAX));
            // the last tap enters the sum before its update
            sum = round_off(x * PINK_DIRECT, 12);
            for (int k = 0; k < NUM_TAPS; k++) sum += pink_tap[k];
            pink_tap[NUM_TAPS-1] = int'(clamp(round_off(x * PINK_TAIL, 12), TAP_MIN, TAP_MAX));
            sum = round_off(sum * PINK_OUT_GAIN, 24);
            y = round_off(sum * g, 24);
         end
         default: y = 0;
      endcase
      return SAMPLE_W'(clamp(y, -32768, 32767));
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] pick_noise();
      int spread;
      spread = 0;
      case ($urandom_range(0, 3))
         0: return SAMPLE_W'($urandom());
         1: return SAMPLE_W'(int'($urandom_range(0, 8191)) - 4096);
         2: begin
            // rough bell shape around zero
            repeat (4) spread += int'($urandom_range(0, 4095)) - 2048;
            return SAMPLE_W'(spread);
         end
         default: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      endcase
   endfunction

   // Drop the request and hold until every predicted word has come back
   task automatic drain_samples();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      drain_samples();
      @(negedge clock);
      csr_if.valid     <= 1'b1;
      csr_if.reg_index <= idx;
      csr_if.wdata     <= data;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      case (idx)
         CSR_MODE:       cur_mode = data[MODE_W-1:0];
         CSR_PHASE_STEP: cur_step = data;
         CSR_GAIN:       cur_gain = data[GAIN_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic send_word(logic signed [SAMPLE_W-1:0] noise, logic first);
      int gap;
      gap = idling ? $urandom_range(0, MAX_IDLE) : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.noise_sample <= noise;
      req_if.buffer_start <= first;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      pending_samples.push_back(predict_sample(noise, first));
   endtask

   task automatic test_off_mode();
      send_word(16'sh7FFF, 1'b1);
      send_word(16'sh8000, 1'b0);
      send_word(-16'sd1, 1'b0);
   endtask

   task automatic test_sine();
      write_reg(CSR_MODE, {30'h3FFF_FFFF, MODE_SINE});
      send_word(16'sh1234, 1'b0);
      write_reg(CSR_PHASE_STEP, 32'h4000_0000);
      repeat (4) send_word(pick_noise(), 1'b0);
      write_reg(CSR_GAIN, 32'hABCD_FFFF);
      repeat (2) send_word(pick_noise(), 1'b0);
      write_reg(CSR_PHASE_STEP, 32'hFFFF_FFFF);
      repeat (2) send_word(pick_noise(), 1'b1);
   endtask

   task automatic test_white();
      write_reg(CSR_MODE, {30'h2AAA_AAAA, MODE_WHITE});
      send_word(16'sh7FFF, 1'b0);
      send_word(16'sh8000, 1'b0);
      send_word(16'sh0001, 1'b0);
      send_word(-16'sd1, 1'b0);
      write_reg(CSR_GAIN, 32'd0);
      send_word(16'sh7FFF, 1'b0);
      write_reg(CSR_GAIN, 32'd32768);
      send_word(16'sh8000, 1'b0);
      send_word(16'sh7FFF, 1'b0);
   endtask

   task automatic test_pink();
      write_reg(CSR_MODE, MODE_PINK);
      send_word(16'sh8000, 1'b1);
      send_word(16'sh7FFF, 1'b0);
      send_word(16'sh7FFF, 1'b0);
      send_word(16'sh8000, 1'b1);
      send_word(16'sh0000, 1'b0);
   endtask

   task automatic test_spare_index();
      write_reg(CSR_SPARE, $urandom());
      send_word(pick_noise(), 1'b0);
      send_word(pick_noise(), 1'b0);
   endtask

   // Long runs of extreme noise drive the slow filter sections into their clamp
   task automatic test_tap_saturation();
      write_reg(CSR_MODE, MODE_PINK);
      write_reg(CSR_GAIN, $urandom_range(0, 32768));
      idling = ($urandom_range(0, 1) != 0);
      send_word(16'sh8000, 1'b1);
      repeat (420) send_word(SAMPLE_W'(-32768 + $urandom_range(0, 255)), 1'b0);
      repeat (120) send_word(SAMPLE_W'(32767 - $urandom_range(0, 255)), 1'b0);
      idling = 1'b1;
   endtask

   task automatic test_random_settings(int target);
      int  sent, buffers, span, pick;
      bit  ragged;
      logic [MODE_W-1:0] m;
      sent = 0;
      while (sent < target) begin
         drain_samples();
         idling = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 3) != 0) begin
            pick = $urandom_range(0, 9);
            m = (pick < 2) ? MODE_SINE : (pick < 4) ? MODE_WHITE :
                (pick < 9) ? MODE_PINK : MODE_OFF;
            write_reg(CSR_MODE, ($urandom() & 32'hFFFF_FFFC) | m);
         end
         if ($urandom_range(0, 2) != 0)
            case ($urandom_range(0, 3))
               0: write_reg(CSR_PHASE_STEP, 32'd0);
               1: write_reg(CSR_PHASE_STEP, 32'hFFFF_FFFF);
               2: write_reg(CSR_PHASE_STEP, $urandom());
               default: write_reg(CSR_PHASE_STEP, $urandom_range(1, 1 << 26));
            endcase
         if ($urandom_range(0, 2) != 0)
            case ($urandom_range(0, 5))
               0: write_reg(CSR_GAIN, 32'd0);
               1: write_reg(CSR_GAIN, 32'd32768);
               2: write_reg(CSR_GAIN, $urandom() | 32'h0000_FFFF);
               3, 4: write_reg(CSR_GAIN, $urandom_range(0, 32768));
               default: write_reg(CSR_GAIN, $urandom());
            endcase
         if ($urandom_range(0, 7) == 0)
            write_reg(CSR_SPARE, $urandom());
         ragged  = ($urandom_range(0, 9) == 0);
         buffers = $urandom_range(1, 4);
         repeat (buffers) begin
            span = $urandom_range(1, 24);
            for (int n = 0; n < span; n++)
               send_word(pick_noise(), ragged ? 1'($urandom_range(0, 1)) : 1'(n == 0));
            sent += span;
         end
      end
      idling = 1'b1;
   endtask

   initial begin : sample_checker
      int stall;
      logic signed [SAMPLE_W-1:0] want;
      rsp_if.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = idling ? $urandom_range(0, MAX_IDLE) : 0;
         if (stall != 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_if.valid) @(posedge clock);
         if (pending_samples.size() == 0) begin
            mismatches++;
            $display("%0t: word with nothing expected, actual %0d", $time, rsp_if.sample_out);
         end else begin
            want = pending_samples.pop_front();
            if (rsp_if.sample_out !== want) begin
               mismatches++;
               $display("%0t: sample_out expected %0d, actual %0d",
                        $time, want, rsp_if.sample_out);
            end
         end
         @(negedge clock);
      end
   end

   initial begin
      reset               = 1'b1;
      req_if.valid        = 1'b0;
      req_if.noise_sample = '0;
      req_if.buffer_start = 1'b0;
      csr_if.valid        = 1'b0;
      csr_if.reg_index    = CSR_MODE;
      csr_if.wdata        = '0;
      cur_mode            = MODE_RESET;
      cur_step            = PHASE_STEP_RESET;
      cur_gain            = GAIN_RESET;
      phase               = '0;
      for (int k = 0; k < NUM_TAPS; k++) pink_tap[k] = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_off_mode();
      test_sine();
      test_white();
      test_pink();
      test_spare_index();
      test_tap_saturation();
      test_random_settings(690);

      drain_samples();
      repeat (40) @(posedge clock);
      if (mismatches == 0 && pending_samples.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   initial begin
      #5000000;
      $display("FAILURE");
      $finish;
   end

endmodule

>>> sim.f
+incdir+sv
sv/atsg_pkg.sv
sv/atsg_intf.sv
sv/atsg_csr.sv
sv/atsg_ctrl.sv
sv/atsg_dp.sv
sv/audio_test_signal_generator_unit.sv
dv/tb_audio_test_signal_generator_unit.sv
